@@ rtl/core/aerp_pkg.sv @@
// Package for the ARM ELF relocation patcher.
// Relocation kind, symbol class and status codes, payload widths and structs.
// Depends on nothing.
package aerp_pkg;

	localparam int unsigned FUNC_W = 4;
	localparam int unsigned KIND_W = 2;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned STAT_W = 3;

	typedef enum logic [FUNC_W-1:0] {
		FN_NONE       = 4'd0,
		FN_ABS32      = 4'd1,
		FN_ARM_B24    = 4'd2,
		FN_THUMB_BL   = 4'd3,
		FN_THUMB_MOVW = 4'd4,
		FN_THUMB_MOVT = 4'd5,
		FN_ARM_MOVW   = 4'd6,
		FN_ARM_MOVT   = 4'd7,
		FN_V4BX       = 4'd8
	} func_t;

	typedef enum logic [KIND_W-1:0] {
		SK_DEFINED = 2'd0,
		SK_UNDEF   = 2'd1,
		SK_COMMON  = 2'd2,
		SK_ABS     = 2'd3
	} sym_kind_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 3'd0,
		ST_UNDEF   = 3'd1,
		ST_COMMON  = 3'd2,
		ST_RANGE   = 3'd3,
		ST_UNKNOWN = 3'd4
	} status_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		sym_kind_t         sym_kind;
		logic [WORD_W-1:0] sym_value;
		logic [WORD_W-1:0] section_base;
		logic [WORD_W-1:0] place_address;
		logic [WORD_W-1:0] original_word;
	} reloc_t;

	typedef struct packed {
		logic [WORD_W-1:0] patched_word;
		status_t           status;
	} result_t;

endpackage

@@ rtl/core/aerp_reloc_if.sv @@
// Relocation input channel: valid/ready handshake plus relocation entry fields.
// Depends on aerp_pkg.
interface aerp_reloc_if;
	logic                              valid;
	logic                              ready;
	logic [aerp_pkg::FUNC_W-1:0]       func;
	logic [aerp_pkg::KIND_W-1:0]       sym_kind;
	logic [aerp_pkg::WORD_W-1:0]       sym_value;
	logic [aerp_pkg::WORD_W-1:0]       section_base;
	logic [aerp_pkg::WORD_W-1:0]       place_address;
	logic [aerp_pkg::WORD_W-1:0]       original_word;

	modport source (
		output valid, func, sym_kind, sym_value, section_base, place_address,
			original_word,
		input  ready
	);
	modport sink (
		input  valid, func, sym_kind, sym_value, section_base, place_address,
			original_word,
		output ready
	);
endinterface

@@ rtl/core/aerp_result_if.sv @@
// Result output channel: valid/ready handshake plus patched word and status.
// Depends on aerp_pkg.
interface aerp_result_if;
	logic                        valid;
	logic                        ready;
	logic [aerp_pkg::WORD_W-1:0] patched_word;
	logic [aerp_pkg::STAT_W-1:0] status;

	modport source (
		output valid, patched_word, status,
		input  ready
	);
	modport sink (
		input  valid, patched_word, status,
		output ready
	);
endinterface

@@ rtl/core/aerp_core.sv @@
// Combinational relocation datapath: symbol resolve, addend decode, add, range check
// and re-encode. Depends on aerp_pkg.
module aerp_core (
	input  aerp_pkg::reloc_t  reloc,
	output aerp_pkg::result_t result
);

	logic [31:0] w;
	logic [31:0] s;
	logic [31:0] addend;
	logic [31:0] place_term;
	logic [31:0] sum;
	logic [15:0] hi;
	logic [15:0] lo;
	logic [15:0] t_imm;
	logic [15:0] a_imm;
	logic [15:0] v16;
	logic [25:0] arm_off;
	logic [24:0] thm_off;
	logic        arm_ok;
	logic        thm_ok;
	logic        sg;
	logic        j1;
	logic        j2;
	logic        is_movt;

	always_comb begin
		w  = reloc.original_word;
		hi = w[15:0];
		lo = w[31:16];
		s  = (reloc.sym_kind == aerp_pkg::SK_ABS) ? reloc.sym_value
			: reloc.section_base + reloc.sym_value;

		// implicit addends
		arm_off = {w[23:0], 2'b00};
		thm_off = {hi[10], ~(lo[13] ^ hi[10]), ~(lo[11] ^ hi[10]), hi[9:0], lo[10:0], 1'b0};
		t_imm   = {hi[3:0], hi[10], lo[14:12], lo[7:0]};
		a_imm   = {w[19:16], w[11:0]};

		addend     = '0;
		place_term = '0;
		unique case (reloc.func)
			aerp_pkg::FN_ABS32: addend = w;
			aerp_pkg::FN_ARM_B24: begin
				addend     = {{6{arm_off[25]}}, arm_off};
				place_term = reloc.place_address;
			end
			aerp_pkg::FN_THUMB_BL: begin
				addend     = {{7{thm_off[24]}}, thm_off};
				place_term = reloc.place_address;
			end
			aerp_pkg::FN_THUMB_MOVW, aerp_pkg::FN_THUMB_MOVT:
				addend = {{16{t_imm[15]}}, t_imm};
			aerp_pkg::FN_ARM_MOVW, aerp_pkg::FN_ARM_MOVT:
				addend = {{16{a_imm[15]}}, a_imm};
			default: addend = '0;
		endcase

		sum     = addend + s - place_term;
		is_movt = (reloc.func == aerp_pkg::FN_THUMB_MOVT) ||
			(reloc.func == aerp_pkg::FN_ARM_MOVT);
		v16     = is_movt ? sum[31:16] : sum[15:0];
		arm_ok  = (sum[31:25] == '0) || (sum[31:25] == '1);
		thm_ok  = (sum[31:24] == '0) || (sum[31:24] == '1);
		sg      = sum[24];
		j1      = sg ^ ~sum[23];
		j2      = sg ^ ~sum[22];

		result.patched_word = w;
		result.status       = aerp_pkg::ST_OK;
		priority if (reloc.func == aerp_pkg::FN_V4BX) begin
			result.status = aerp_pkg::ST_OK;
		end else if (reloc.sym_kind == aerp_pkg::SK_UNDEF) begin
			result.status = aerp_pkg::ST_UNDEF;
		end else if (reloc.sym_kind == aerp_pkg::SK_COMMON) begin
			result.status = aerp_pkg::ST_COMMON;
		end else begin
			unique case (reloc.func)
				aerp_pkg::FN_NONE: result.patched_word = w;
				aerp_pkg::FN_ABS32: result.patched_word = sum;
				aerp_pkg::FN_ARM_B24: begin
					if (arm_ok)
						result.patched_word = {w[31:24], sum[25:2]};
					else
						result.status = aerp_pkg::ST_RANGE;
				end
				aerp_pkg::FN_THUMB_BL: begin
					if (thm_ok)
						result.patched_word = {lo[15:14], j1, lo[12], j2, sum[11:1],
							hi[15:11], sg, sum[21:12]};
					else
						result.status = aerp_pkg::ST_RANGE;
				end
				aerp_pkg::FN_THUMB_MOVW, aerp_pkg::FN_THUMB_MOVT:
					result.patched_word = {lo[15], v16[10:8], lo[11:8], v16[7:0],
						hi[15:11], v16[11], hi[9:4], v16[15:12]};
				aerp_pkg::FN_ARM_MOVW, aerp_pkg::FN_ARM_MOVT:
					result.patched_word = {w[31:20], v16[15:12], w[15:12], v16[11:0]};
				default: result.status = aerp_pkg::ST_UNKNOWN;
			endcase
		end
	end

endmodule

@@ rtl/core/arm_elf_relocation_patcher.sv @@
// ARM ELF relocation patcher top level: input register, patch datapath, result register.
// A relocation passes through the input register and then the result register before
// its result is offered. Throughput: one relocation per cycle while result.ready is
// high; the result register lets another input be taken while a finished result waits.
// Reset (arst_n low, asynchronous) empties both stages.
// Depends on aerp_pkg, aerp_reloc_if, aerp_result_if, aerp_core.
module arm_elf_relocation_patcher (
	input  logic                 clk,
	input  logic                 arst_n,
	aerp_reloc_if.sink           reloc,
	aerp_result_if.source        result
);

	logic              valid_s1;
	logic              valid_s2;
	aerp_pkg::reloc_t  reloc_s1;
	aerp_pkg::result_t res_s2;
	aerp_pkg::result_t res_comb;
	logic              adv2;
	logic              take;

	assign adv2        = !valid_s2 || result.ready;
	assign reloc.ready = !valid_s1 || adv2;
	assign take        = reloc.valid && reloc.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (reloc.ready)
				valid_s1 <= reloc.valid;
			if (adv2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			reloc_s1.func          <= reloc.func;
			reloc_s1.sym_kind      <= aerp_pkg::sym_kind_t'(reloc.sym_kind);
			reloc_s1.sym_value     <= reloc.sym_value;
			reloc_s1.section_base  <= reloc.section_base;
			reloc_s1.place_address <= reloc.place_address;
			reloc_s1.original_word <= reloc.original_word;
		end
		if (valid_s1 && adv2)
			res_s2 <= res_comb;
	end

	aerp_core u_core (
		.reloc  (reloc_s1),
		.result (res_comb)
	);

	assign result.valid        = valid_s2;
	assign result.patched_word = res_s2.patched_word;
	assign result.status       = res_s2.status;

`ifndef ASSERT_OFF
	a_ready_only_on_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!reloc.ready |-> (valid_s1 && valid_s2 && !result.ready))
		else $error("input stalled without a full pipeline");

	a_s1_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv2) |=> (valid_s1 && $stable(reloc_s1)))
		else $error("stage 1 item lost during output stall");

	a_s1_moves_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv2) |=> valid_s2)
		else $error("stage 1 item not carried into result register");
`endif

endmodule
